// ----- rtl/tts_pkg.sv -----
// shared types, constants and functions for the ttl text to seconds block
`timescale 1ns / 1ps

package tts_pkg;

    localparam int unsigned NUM_W  = 32;
    localparam int unsigned TTL_W  = 31;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ARG_W  = 4;
    localparam int unsigned SCALE_W = 20;

    localparam logic [TTL_W-1:0] TTL_FALLBACK_RESET = TTL_W'(3600);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [SCALE_W-1:0] SCALE_MIN  = SCALE_W'(60);
    localparam logic [SCALE_W-1:0] SCALE_HOUR = SCALE_W'(60 * 60);
    localparam logic [SCALE_W-1:0] SCALE_DAY  = SCALE_W'(60 * 60 * 24);
    localparam logic [SCALE_W-1:0] SCALE_WEEK = SCALE_W'(60 * 60 * 24 * 7);

    // unit letter codes carried in the token argument
    localparam logic [ARG_W-1:0] UNIT_SEC  = ARG_W'(0);
    localparam logic [ARG_W-1:0] UNIT_MIN  = ARG_W'(1);
    localparam logic [ARG_W-1:0] UNIT_HOUR = ARG_W'(2);
    localparam logic [ARG_W-1:0] UNIT_DAY  = ARG_W'(3);
    localparam logic [ARG_W-1:0] UNIT_WEEK = ARG_W'(4);

    typedef enum logic [1:0] {
        TK_DIGIT,
        TK_UNIT,
        TK_TERM
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t        kind;
        logic [ARG_W-1:0] arg;
        logic [POS_W-1:0] offset;
    } token_t;

    function automatic logic [SCALE_W-1:0] unit_scale(input logic [ARG_W-1:0] code);
        logic [SCALE_W-1:0] s;
        begin
            unique case (code)
                UNIT_SEC:  s = SCALE_W'(1);
                UNIT_MIN:  s = SCALE_MIN;
                UNIT_HOUR: s = SCALE_HOUR;
                UNIT_DAY:  s = SCALE_DAY;
                UNIT_WEEK: s = SCALE_WEEK;
                default:   s = '0;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- rtl/tts_front.sv -----
// front end: byte classification, position count and token queue
`timescale 1ns / 1ps

module tts_front
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_code,
    output logic              tok_valid,
    input  logic              tok_ready,
    output token_t            tok
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    token_t             q_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic       accept;
    logic       pop_tok;
    logic       wr_tok;
    token_t     new_tok;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign tok_valid = (count_reg != '0);
    assign tok       = q_mem[rd_ptr_reg];
    assign accept    = push && !full;
    assign pop_tok   = tok_valid && tok_ready;

    always_comb
    begin
        wr_tok         = 1'b1;
        new_tok.kind   = TK_TERM;
        new_tok.arg    = '0;
        new_tok.offset = pos_reg;
        if (char_code >= "0" && char_code <= "9")
        begin
            new_tok.kind = TK_DIGIT;
            new_tok.arg  = ARG_W'(char_code - CHAR_W'("0"));
        end
        else
        begin
            unique case (char_code)
                " ", 8'h09:
                    wr_tok = 1'b0;
                "s", "S":
                begin
                    new_tok.kind = TK_UNIT;
                    new_tok.arg  = UNIT_SEC;
                end
                "m", "M":
                begin
                    new_tok.kind = TK_UNIT;
                    new_tok.arg  = UNIT_MIN;
                end
                "h", "H":
                begin
                    new_tok.kind = TK_UNIT;
                    new_tok.arg  = UNIT_HOUR;
                end
                "d", "D":
                begin
                    new_tok.kind = TK_UNIT;
                    new_tok.arg  = UNIT_DAY;
                end
                "w", "W":
                begin
                    new_tok.kind = TK_UNIT;
                    new_tok.arg  = UNIT_WEEK;
                end
                default:
                    new_tok.kind = TK_TERM;
            endcase
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            // terminator starts a new text, everything else counts up saturating
            if (wr_tok && new_tok.kind == TK_TERM)
                pos_next = '0;
            else if (pos_reg != POS_MAX)
                pos_next = pos_reg + POS_W'(1);
        end
        if (accept && wr_tok)
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        if (pop_tok)
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        if ((accept && wr_tok) && !pop_tok)
            count_next = count_reg + CNT_W'(1);
        else if (!(accept && wr_tok) && pop_tok)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_tok)
            q_mem[wr_ptr_reg] <= new_tok;
    end

endmodule

// ----- rtl/tts_back.sv -----
// back end: number and total accumulation plus result queue
`timescale 1ns / 1ps

module tts_back
    import tts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tok_valid,
    output logic             tok_ready,
    input  token_t           tok,
    input  logic [TTL_W-1:0] ttl_fallback_val,
    output logic             empty,
    input  logic             pop,
    output logic [TTL_W-1:0] ttl_seconds,
    output logic             used_default,
    output logic [POS_W-1:0] stop_offset
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [TTL_W-1:0] ttl;
        logic             used_def;
        logic [POS_W-1:0] offset;
    } result_t;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] sec_reg, sec_next;
    logic [NUM_W-1:0] prod_reg, prod_next;

    result_t          r_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             res_full;
    logic             take;
    logic             res_push;
    logic             res_pop;
    logic [NUM_W-1:0] total;
    result_t          new_res;

    assign res_full  = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign tok_ready = !(tok.kind == TK_TERM && res_full);
    assign take      = tok_valid && tok_ready;
    assign res_push  = take && tok.kind == TK_TERM;
    assign res_pop   = pop && !empty;

    assign ttl_seconds  = r_mem[rd_ptr_reg].ttl;
    assign used_default = r_mem[rd_ptr_reg].used_def;
    assign stop_offset  = r_mem[rd_ptr_reg].offset;

    // the last unit product waits in prod_reg until the next unit letter or terminator
    assign total            = sec_reg + prod_reg + num_reg;
    assign new_res.used_def = total[NUM_W-1];
    assign new_res.ttl      = total[NUM_W-1] ? ttl_fallback_val : total[TTL_W-1:0];
    assign new_res.offset   = tok.offset;

    always_comb
    begin
        num_next  = num_reg;
        sec_next  = sec_reg;
        prod_next = prod_reg;
        if (take)
        begin
            unique case (tok.kind)
                TK_DIGIT:
                    num_next = (num_reg << 3) + (num_reg << 1)
                             + NUM_W'(tok.arg);
                TK_UNIT:
                begin
                    prod_next = NUM_W'(num_reg * unit_scale(tok.arg));
                    sec_next  = sec_reg + prod_reg;
                    num_next  = '0;
                end
                TK_TERM:
                begin
                    num_next  = '0;
                    sec_next  = '0;
                    prod_next = '0;
                end
                default:
                    num_next = num_reg;
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_push)
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        if (res_pop)
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        if (res_push && !res_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!res_push && res_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg    <= '0;
            sec_reg    <= '0;
            prod_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            num_reg    <= num_next;
            sec_reg    <= sec_next;
            prod_reg   <= prod_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            r_mem[wr_ptr_reg] <= new_res;
    end

endmodule

// ----- rtl/ttl_text_to_seconds_core.sv -----
// Parses DNS TTL text such as 1w2d3h into seconds, one byte per clock. A byte is taken
// whenever full is low, so the block sustains one byte per clock while both queues move;
// full rises only when two results wait unpopped and the four-entry token queue backs up
// behind the next terminator. While the result queue has room, a terminator's result is
// written there as the back end takes it from the token queue. The front end classifies
// each byte into the token queue; the back end accumulates digits and unit products (the
// product of one unit letter is folded in at the next unit letter or terminator), and
// keeps a two-entry result queue. Blanks are skipped, a byte that is neither digit,
// unit letter nor blank ends the text and yields one result. When bit 31 of the total is
// set the ttl_fallback register (reset 3600) is reported instead and used_default is high.
// stop_offset saturates at 65535. Write ttl_fallback only while the block is idle.
`timescale 1ns / 1ps

module ttl_text_to_seconds_core
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_code,
    output logic              empty,
    input  logic              pop,
    output logic [TTL_W-1:0]  ttl_seconds,
    output logic              used_default,
    output logic [POS_W-1:0]  stop_offset,
    input  logic              ttl_fallback_wr,
    input  logic [TTL_W-1:0]  ttl_fallback
);

    logic [TTL_W-1:0] ttl_fallback_reg;
    logic             tok_valid;
    logic             tok_ready;
    token_t           tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ttl_fallback_reg <= TTL_FALLBACK_RESET;
        else if (ttl_fallback_wr)
            ttl_fallback_reg <= ttl_fallback;
    end

    tts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    tts_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .tok_valid        (tok_valid),
        .tok_ready        (tok_ready),
        .tok              (tok),
        .ttl_fallback_val (ttl_fallback_reg),
        .empty            (empty),
        .pop              (pop),
        .ttl_seconds      (ttl_seconds),
        .used_default     (used_default),
        .stop_offset      (stop_offset)
    );

    // a result reporting the default carries the configured value
    a_default_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && used_default) |-> (ttl_seconds == ttl_fallback_reg))
        else $error("default result does not match ttl_fallback");

    // back end stalls a terminator only while results are waiting
    a_term_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_ready) |-> (!empty && tok.kind == TK_TERM))
        else $error("back end stalled without pending results");

    // digit and unit tokens never stall the back end
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok.kind != TK_TERM) |-> tok_ready)
        else $error("non-terminator token stalled");

endmodule
